>>> sv/ipv4fwd_pkg.sv
// ----------------------------------------------------------------------------
// ipv4fwd_pkg
// Shared types, codes and helpers of the IPv4 forwarding header update block.
// ----------------------------------------------------------------------------
package ipv4fwd_pkg;

   localparam int WORD_W    = 32;
   localparam int VB_W      = 3;
   localparam int VERDICT_W = 3;
   localparam int CSR_W     = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TTL  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_ADD = 1'd1;

   localparam logic [CSR_W-1:0] MIN_TTL_RESET  = 8'd2;
   localparam logic [CSR_W-1:0] DEST_ADD_RESET = 8'd1;

   localparam logic [15:0] ETHTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETHTYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETHTYPE_IPV6 = 16'h86DD;

   localparam int ETH_HDR_BYTES  = 14;
   localparam int MIN_IPV4_BYTES = 34;
   localparam int HDR_END_RESET  = 74;
   localparam int CSUM_OFFSET    = 24;

   localparam logic [VB_W-1:0] FULL_WORD_BYTES = 3'd4;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_FORWARD    = 3'd0,
      VERDICT_OTHER_TYPE = 3'd1,
      VERDICT_ARP_IPV6   = 3'd2,
      VERDICT_SHORT      = 3'd3,
      VERDICT_BAD_CSUM   = 3'd4,
      VERDICT_TTL_LOW    = 3'd5
   } verdict_type;

   typedef struct packed {
      logic hold_acc;
      logic judge;
      logic rd_issue;
      logic out_held;
      logic pass_acc;
      logic restart;
   } dp_cmd_type;

   typedef struct packed {
      logic hdr_done;
      logic rd_fin;
      logic frame_last;
      logic out_free;
      logic in_last;
   } dp_sts_type;

   // Ones'-complement add of two halfwords into a folded 16-bit sum.
   function automatic logic [15:0] ones_add(input logic [15:0] acc,
                                            input logic [15:0] a,
                                            input logic [15:0] b);
      logic [17:0] s;
      logic [16:0] s1;
      s  = {2'b00, acc} + {2'b00, a} + {2'b00, b};
      s1 = {1'b0, s[15:0]} + {15'd0, s[17:16]};
      return s1[15:0] + {15'd0, s1[16]};
   endfunction

endpackage

>>> sv/ipv4fwd_req_if.sv
// ----------------------------------------------------------------------------
// ipv4fwd_req_if
// Frame word channel into the block: valid/ready with word payload.
// ----------------------------------------------------------------------------
interface ipv4fwd_req_if import ipv4fwd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word;
   logic [VB_W-1:0]   valid_bytes;
   logic              frame_end;

   modport source (output valid, word, valid_bytes, frame_end, input ready);
   modport sink   (input valid, word, valid_bytes, frame_end, output ready);
endinterface

>>> sv/ipv4fwd_rsp_if.sv
// ----------------------------------------------------------------------------
// ipv4fwd_rsp_if
// Frame word channel out of the block: valid/ready with word and verdict.
// ----------------------------------------------------------------------------
interface ipv4fwd_rsp_if import ipv4fwd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_W-1:0]    out_word;
   logic [VB_W-1:0]      out_valid_bytes;
   logic                 out_last;
   logic [VERDICT_W-1:0] verdict;

   modport source (output valid, out_word, out_valid_bytes, out_last, verdict,
                   input ready);
   modport sink   (input valid, out_word, out_valid_bytes, out_last, verdict,
                   output ready);
endinterface

>>> sv/ipv4_forward_header_update.sv
// ----------------------------------------------------------------------------
// ipv4_forward_header_update
// IPv4 forwarding header update: TTL decrement, destination rewrite and
// checksum regeneration on a 32-bit Ethernet frame word stream.
// ----------------------------------------------------------------------------
// Each frame's leading words are held in a HOLD_WORDS-deep RAM until the IPv4
// header is complete (at least 34 bytes, up to 14 + 4*IHL), the frame ends,
// the ethertype shows a non-IPv4 frame, or the RAM fills. While words are held
// one word is taken per cycle and the original and patched header checksums
// are summed as they arrive. A judge state then settles the verdict, after
// which the held words are drained one by one (RAM read, then output register
// load) while the input is stalled; the rest of the frame then passes through
// at one word per cycle while the output register is free. Forwarded frames
// carry TTL - 1, destination bytes plus csr dest_add and a fresh checksum;
// other frames pass unchanged. The verdict code rides on the last word of each
// frame.
module ipv4_forward_header_update import ipv4fwd_pkg::*; #(
   parameter int HOLD_WORDS = 19
) (
   input  logic                 clock,
   input  logic                 reset,
   ipv4fwd_req_if.sink          req_bus,
   ipv4fwd_rsp_if.source        rsp_bus,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   logic [CSR_W-1:0] min_ttl_ff;
   logic [CSR_W-1:0] dest_add_ff;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Configuration registers; the user must write them only between transactions, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ttl_ff  <= MIN_TTL_RESET;
         dest_add_ff <= DEST_ADD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MIN_TTL:  min_ttl_ff  <= csr_write_data;
            CSR_DEST_ADD: dest_add_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Sequence hold, judge, drain and pass-through phases.
   ipv4fwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold buffer, checksum sums, verdict and the output register.
   ipv4fwd_dp #(
      .HOLD_WORDS (HOLD_WORDS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .in_word         (req_bus.word),
      .in_valid_bytes  (req_bus.valid_bytes),
      .in_frame_end    (req_bus.frame_end),
      .min_ttl         (min_ttl_ff),
      .dest_add        (dest_add_ff),
      .out_ready       (rsp_bus.ready),
      .out_valid       (rsp_bus.valid),
      .out_word        (rsp_bus.out_word),
      .out_valid_bytes (rsp_bus.out_valid_bytes),
      .out_last        (rsp_bus.out_last),
      .out_verdict     (rsp_bus.verdict)
   );

endmodule

>>> sv/ipv4fwd_ram.sv
// ----------------------------------------------------------------------------
// ipv4fwd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipv4fwd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 19
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/ipv4fwd_ctrl.sv
// ----------------------------------------------------------------------------
// ipv4fwd_ctrl
// Sequencer: hold header words, judge, drain held words, pass the rest.
// ----------------------------------------------------------------------------
module ipv4fwd_ctrl import ipv4fwd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_HOLD  = 5'b00001,
      ST_JUDGE = 5'b00010,
      ST_READ  = 5'b00100,
      ST_LOAD  = 5'b01000,
      ST_PASS  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_HOLD: begin
            req_ready    = 1'b1;
            cmd.hold_acc = req_valid;
            if (req_valid && sts.hdr_done) begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            cmd.judge = 1'b1;
            state_in  = ST_READ;
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_LOAD;
         end
         ST_LOAD: begin
            if (sts.out_free) begin
               cmd.out_held = 1'b1;
               if (!sts.rd_fin) begin
                  state_in = ST_READ;
               end else if (sts.frame_last) begin
                  cmd.restart = 1'b1;
                  state_in    = ST_HOLD;
               end else begin
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            req_ready    = sts.out_free;
            cmd.pass_acc = req_valid && sts.out_free;
            if (cmd.pass_acc && sts.in_last) begin
               cmd.restart = 1'b1;
               state_in    = ST_HOLD;
            end
         end
         default: begin
            state_in = ST_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HOLD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/ipv4fwd_dp.sv
// ----------------------------------------------------------------------------
// ipv4fwd_dp
// Datapath: hold buffer, running checksums, verdict and output register.
// ----------------------------------------------------------------------------
module ipv4fwd_dp import ipv4fwd_pkg::*; #(
   parameter int HOLD_WORDS = 19
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_sts_type           sts,
   input  logic [WORD_W-1:0]    in_word,
   input  logic [VB_W-1:0]      in_valid_bytes,
   input  logic                 in_frame_end,
   input  logic [CSR_W-1:0]     min_ttl,
   input  logic [CSR_W-1:0]     dest_add,
   input  logic                 out_ready,
   output logic                 out_valid,
   output logic [WORD_W-1:0]    out_word,
   output logic [VB_W-1:0]      out_valid_bytes,
   output logic                 out_last,
   output logic [VERDICT_W-1:0] out_verdict
);

   localparam int ADDR_W = $clog2(HOLD_WORDS);
   localparam int IDX_W  = $clog2(HOLD_WORDS + 1);
   localparam int BYTE_W = $clog2(4 * HOLD_WORDS + 1);

   // Word slots of the header fields that are read or patched.
   localparam int W_TYPE    = 3;
   localparam int W_TTL     = 5;
   localparam int W_CSUM    = 6;
   localparam int W_DEST_LO = 7;
   localparam int W_DEST_HI = 8;

   logic [IDX_W-1:0]    idx_ff;
   logic [BYTE_W-1:0]   hdr_end_ff;
   logic [15:0]         acc_orig_ff;
   logic [15:0]         acc_mod_ff;
   logic [BYTE_W-1:0]   bytes_ff;
   logic [VB_W-1:0]     eff_ff;
   logic                last_ff;
   logic [15:0]         type_ff;
   logic [3:0]          ihl_ff;
   logic [7:0]          ttl_ff;
   logic [15:0]         csum_ff;
   verdict_type         verdict_ff;
   logic [ADDR_W-1:0]   rd_idx_ff;
   logic                out_valid_ff;
   logic [WORD_W-1:0]   out_word_ff;
   logic [VB_W-1:0]     out_vb_ff;
   logic                out_last_ff;
   logic [VERDICT_W-1:0] out_verdict_ff;

   logic [VB_W-1:0]   eff;
   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] word_m;
   logic [BYTE_W-1:0] bytes_new;
   logic [IDX_W-1:0]  idx_new;
   logic              at_type, at_ttl, at_dest_lo, at_dest_hi;
   logic [3:0]        ihl_now;
   logic [15:0]       type_now;
   logic [BYTE_W-1:0] lim, lim_clamp, hdr_end_now;
   logic [BYTE_W-1:0] off_hi, off_lo;
   logic              in_hi, in_lo;
   logic [15:0]       hw_hi, hw_lo, hwm_hi, hwm_lo;
   logic [7:0]        ttl_dec;
   verdict_type       verdict_now;
   logic [WORD_W-1:0] ram_q;
   logic [WORD_W-1:0] held_word;
   logic              fwd;

   // Effective byte count and masking of the incoming word.
   always_comb begin
      eff = FULL_WORD_BYTES;
      if (in_frame_end && in_valid_bytes >= VB_W'(1) && in_valid_bytes <= FULL_WORD_BYTES) begin
         eff = in_valid_bytes;
      end
      unique case (eff)
         VB_W'(1): mask = 32'hFF00_0000;
         VB_W'(2): mask = 32'hFFFF_0000;
         VB_W'(3): mask = 32'hFFFF_FF00;
         default:  mask = 32'hFFFF_FFFF;
      endcase
   end

   assign word_m    = in_word & mask;
   assign bytes_new = BYTE_W'({idx_ff, 2'b00}) + BYTE_W'(eff);
   assign idx_new   = idx_ff + IDX_W'(1);

   assign at_type    = (idx_ff == IDX_W'(W_TYPE));
   assign at_ttl     = (idx_ff == IDX_W'(W_TTL));
   assign at_dest_lo = (idx_ff == IDX_W'(W_DEST_LO));
   assign at_dest_hi = (idx_ff == IDX_W'(W_DEST_HI));

   assign ihl_now  = at_type ? word_m[11:8] : ihl_ff;
   assign type_now = at_type ? word_m[31:16] : type_ff;

   // Header extent and checksum coverage of this word's two halfwords.
   always_comb begin
      lim       = BYTE_W'(ETH_HDR_BYTES) + BYTE_W'({ihl_now, 2'b00});
      lim_clamp = (lim < BYTE_W'(MIN_IPV4_BYTES)) ? BYTE_W'(MIN_IPV4_BYTES) : lim;
      hdr_end_now = hdr_end_ff;
      if (bytes_new >= BYTE_W'(ETH_HDR_BYTES + 1) && type_now == ETHTYPE_IPV4) begin
         hdr_end_now = lim_clamp;
      end
      off_hi = BYTE_W'({idx_ff, 2'b00});
      off_lo = off_hi + BYTE_W'(2);
      in_hi  = off_hi >= BYTE_W'(ETH_HDR_BYTES) && off_hi < lim &&
               off_hi != BYTE_W'(CSUM_OFFSET);
      in_lo  = off_lo >= BYTE_W'(ETH_HDR_BYTES) && off_lo < lim &&
               off_lo != BYTE_W'(CSUM_OFFSET);
      ttl_dec = word_m[15:8] - 8'd1;
      hwm_lo  = word_m[15:0];
      if (at_ttl) begin
         hwm_lo = {ttl_dec, word_m[7:0]};
      end else if (at_dest_lo) begin
         hwm_lo = {word_m[15:8] + dest_add, word_m[7:0] + dest_add};
      end
      hwm_hi = word_m[31:16];
      if (at_dest_hi) begin
         hwm_hi = {word_m[31:24] + dest_add, word_m[23:16] + dest_add};
      end
      hw_hi  = in_hi ? word_m[31:16] : 16'd0;
      hw_lo  = in_lo ? word_m[15:0] : 16'd0;
      hwm_hi = in_hi ? hwm_hi : 16'd0;
      hwm_lo = in_lo ? hwm_lo : 16'd0;
   end

   // Verdict from the fully held header.
   always_comb begin
      priority if (bytes_ff < BYTE_W'(ETH_HDR_BYTES)) begin
         verdict_now = VERDICT_OTHER_TYPE;
      end else if (type_ff == ETHTYPE_ARP || type_ff == ETHTYPE_IPV6) begin
         verdict_now = VERDICT_ARP_IPV6;
      end else if (type_ff != ETHTYPE_IPV4) begin
         verdict_now = VERDICT_OTHER_TYPE;
      end else if (bytes_ff < BYTE_W'(MIN_IPV4_BYTES)) begin
         verdict_now = VERDICT_SHORT;
      end else if (~acc_orig_ff != csum_ff) begin
         verdict_now = VERDICT_BAD_CSUM;
      end else if (ttl_ff < min_ttl) begin
         verdict_now = VERDICT_TTL_LOW;
      end else begin
         verdict_now = VERDICT_FORWARD;
      end
   end

   ipv4fwd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (HOLD_WORDS)
   ) u_hold_ram (
      .clock   (clock),
      .wr_en   (cmd.hold_acc),
      .wr_addr (idx_ff[ADDR_W-1:0]),
      .wr_data (word_m),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_q)
   );

   // Patch the held header words of a forwarded frame on the way out.
   assign fwd = (verdict_ff == VERDICT_FORWARD);

   always_comb begin
      held_word = ram_q;
      if (fwd) begin
         if (rd_idx_ff == ADDR_W'(W_TTL)) begin
            held_word[15:8] = ttl_ff - 8'd1;
         end else if (rd_idx_ff == ADDR_W'(W_CSUM)) begin
            held_word[31:16] = ~acc_mod_ff;
         end else if (rd_idx_ff == ADDR_W'(W_DEST_LO)) begin
            held_word[15:8] = ram_q[15:8] + dest_add;
            held_word[7:0]  = ram_q[7:0] + dest_add;
         end else if (rd_idx_ff == ADDR_W'(W_DEST_HI)) begin
            held_word[31:24] = ram_q[31:24] + dest_add;
            held_word[23:16] = ram_q[23:16] + dest_add;
         end
      end
   end

   always_comb begin
      sts.hdr_done = in_frame_end ||
                     (bytes_new >= BYTE_W'(ETH_HDR_BYTES) && type_now != ETHTYPE_IPV4) ||
                     bytes_new >= hdr_end_now ||
                     idx_new >= IDX_W'(HOLD_WORDS);
      sts.rd_fin     = (IDX_W'(rd_idx_ff) + IDX_W'(1) == idx_ff);
      sts.frame_last = last_ff;
      sts.out_free   = !out_valid_ff || out_ready;
      sts.in_last    = in_frame_end;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         hdr_end_ff   <= BYTE_W'(HDR_END_RESET);
         acc_orig_ff  <= '0;
         acc_mod_ff   <= '0;
         verdict_ff   <= VERDICT_FORWARD;
         rd_idx_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.restart) begin
            idx_ff      <= '0;
            hdr_end_ff  <= BYTE_W'(HDR_END_RESET);
            acc_orig_ff <= '0;
            acc_mod_ff  <= '0;
         end else if (cmd.hold_acc) begin
            idx_ff      <= idx_new;
            hdr_end_ff  <= hdr_end_now;
            acc_orig_ff <= ones_add(acc_orig_ff, hw_hi, hw_lo);
            acc_mod_ff  <= ones_add(acc_mod_ff, hwm_hi, hwm_lo);
         end
         if (cmd.judge) begin
            verdict_ff <= verdict_now;
            rd_idx_ff  <= '0;
         end else if (cmd.out_held && !sts.rd_fin) begin
            rd_idx_ff <= rd_idx_ff + ADDR_W'(1);
         end
         if (cmd.out_held || cmd.pass_acc) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.hold_acc) begin
         bytes_ff <= bytes_new;
         eff_ff   <= eff;
         last_ff  <= in_frame_end;
         if (at_type) begin
            type_ff <= word_m[31:16];
            ihl_ff  <= word_m[11:8];
         end
         if (at_ttl) begin
            ttl_ff <= word_m[15:8];
         end
         if (idx_ff == IDX_W'(W_CSUM)) begin
            csum_ff <= word_m[31:16];
         end
      end
      if (cmd.out_held) begin
         out_word_ff    <= held_word;
         out_vb_ff      <= sts.rd_fin ? eff_ff : FULL_WORD_BYTES;
         out_last_ff    <= sts.rd_fin && last_ff;
         out_verdict_ff <= (sts.rd_fin && last_ff) ? verdict_ff : VERDICT_FORWARD;
      end else if (cmd.pass_acc) begin
         out_word_ff    <= word_m;
         out_vb_ff      <= eff;
         out_last_ff    <= in_frame_end;
         out_verdict_ff <= in_frame_end ? verdict_ff : VERDICT_FORWARD;
      end
   end

   assign out_valid       = out_valid_ff;
   assign out_word        = out_word_ff;
   assign out_valid_bytes = out_vb_ff;
   assign out_last        = out_last_ff;
   assign out_verdict     = out_verdict_ff;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IPv4 forwarding header update block. Frames of
// every kind are streamed in bursts under several csr settings. A scoreboard
// predicts the output word stream and checks every output transaction.
// ----------------------------------------------------------------------------
module testbench;
   import ipv4fwd_pkg::*;

   localparam int HOLD       = 19;
   localparam int DRAIN_WAIT = 120;
   localparam int CYCLE_CAP  = 400000;

   typedef struct {
      logic [WORD_W-1:0]    out_word;
      logic [VB_W-1:0]      nbytes;
      logic                 last;
      logic [VERDICT_W-1:0] verdict;
   } fwd_word_type;

   // Predicts the forwarded word stream and holds the words still owed.
   class fwd_scoreboard;
      logic [31:0]  hold [HOLD];
      int           held_cnt;
      int           hdr_end;
      bit           holding;
      verdict_type  frame_vd;
      logic [7:0]   ttl_floor;
      logic [7:0]   dest_add;
      fwd_word_type owed [$];
      int           errors;

      function new();
         held_cnt  = 0;
         hdr_end   = HDR_END_RESET;
         holding   = 1;
         frame_vd  = VERDICT_FORWARD;
         ttl_floor = MIN_TTL_RESET;
         dest_add  = DEST_ADD_RESET;
         errors    = 0;
      endfunction

      function void restart();
         held_cnt = 0;
         hdr_end  = HDR_END_RESET;
         holding  = 1;
         frame_vd = VERDICT_FORWARD;
      endfunction

      function logic [7:0] held_byte(int i);
         int w;
         w = i >> 2;
         if (w >= held_cnt || w >= HOLD) return 8'h00;
         return hold[w][8*(3-(i%4)) +: 8];
      endfunction

      function void set_byte(int i, logic [7:0] v);
         int w;
         w = i >> 2;
         if (w >= held_cnt || w >= HOLD) return;
         hold[w][8*(3-(i%4)) +: 8] = v;
      endfunction

      function logic [15:0] ip_csum();
         int ihl;
         int off;
         int acc;
         ihl = held_byte(ETH_HDR_BYTES) & 8'h0f;
         acc = 0;
         for (int h = 0; h < ihl * 2; h++) begin
            off = ETH_HDR_BYTES + 2 * h;
            if (off == CSUM_OFFSET) continue;
            acc += {held_byte(off), held_byte(off + 1)};
            acc = (acc & 16'hffff) + (acc >> 16);
         end
         return ~acc[15:0];
      endfunction

      function verdict_type rule_on(int total);
         logic [15:0] etype;
         logic [15:0] c;
         logic [7:0]  ttl;
         if (total < ETH_HDR_BYTES) return VERDICT_OTHER_TYPE;
         etype = {held_byte(12), held_byte(13)};
         if (etype == ETHTYPE_ARP || etype == ETHTYPE_IPV6) return VERDICT_ARP_IPV6;
         if (etype != ETHTYPE_IPV4) return VERDICT_OTHER_TYPE;
         if (total < MIN_IPV4_BYTES) return VERDICT_SHORT;
         if (ip_csum() != {held_byte(CSUM_OFFSET), held_byte(CSUM_OFFSET + 1)})
            return VERDICT_BAD_CSUM;
         ttl = held_byte(22);
         if (ttl < ttl_floor) return VERDICT_TTL_LOW;
         set_byte(22, ttl - 8'd1);
         for (int j = 30; j < 34; j++) set_byte(j, held_byte(j) + dest_add);
         c = ip_csum();
         set_byte(CSUM_OFFSET, c[15:8]);
         set_byte(CSUM_OFFSET + 1, c[7:0]);
         return VERDICT_FORWARD;
      endfunction

      // Note one accepted input transaction and queue the words it releases.
      function void note_input(logic [31:0] w_in, logic [2:0] vb, logic fin);
         int           eff;
         int           nbytes;
         int           he;
         logic [31:0]  w;
         logic [15:0]  etype;
         fwd_word_type e;
         bit           release_now;
         eff = (fin && vb >= 1 && vb <= 4) ? vb : 4;
         w   = w_in & (32'hffffffff << (8 * (4 - eff)));
         if (!holding) begin
            e.out_word = w;
            e.nbytes   = VB_W'(eff);
            e.last     = fin;
            e.verdict  = fin ? frame_vd : VERDICT_FORWARD;
            owed.insert(owed.size(), e);
            if (fin) restart();
            return;
         end
         if (held_cnt >= HOLD) held_cnt = HOLD - 1;
         hold[held_cnt] = w;
         held_cnt++;
         nbytes = 4 * (held_cnt - 1) + eff;
         etype  = {held_byte(12), held_byte(13)};
         if (nbytes >= 15 && etype == ETHTYPE_IPV4) begin
            he      = ETH_HDR_BYTES + 4 * (held_byte(ETH_HDR_BYTES) & 8'h0f);
            hdr_end = he < MIN_IPV4_BYTES ? MIN_IPV4_BYTES : he;
         end
         release_now = fin || (nbytes >= ETH_HDR_BYTES && etype != ETHTYPE_IPV4) ||
                       nbytes >= hdr_end || held_cnt >= HOLD;
         if (!release_now) return;
         frame_vd = rule_on(nbytes);
         for (int k = 0; k < held_cnt; k++) begin
            e.out_word = hold[k];
            e.nbytes   = VB_W'((k + 1 == held_cnt) ? eff : 4);
            e.last     = (k + 1 == held_cnt) && fin;
            e.verdict  = e.last ? frame_vd : VERDICT_FORWARD;
            owed.insert(owed.size(), e);
         end
         if (fin) restart();
         else holding = 0;
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("MISMATCH %s: got %h expected %h", what, got, want);
         errors++;
      endtask

      // Compare one output transaction with the oldest owed word.
      task check_result(logic [31:0] w, logic [2:0] vb, logic fin, logic [2:0] vd);
         fwd_word_type e;
         if (owed.size() == 0) begin
            report_mismatch("unexpected word", w, 32'h0);
            return;
         end
         e = owed.pop_front();
         if (w !== e.out_word)   report_mismatch("out_word", w, e.out_word);
         if (vb !== e.nbytes)    report_mismatch("out_valid_bytes", vb, e.nbytes);
         if (fin !== e.last)     report_mismatch("out_last", fin, e.last);
         if (vd !== e.verdict)   report_mismatch("verdict", vd, e.verdict);
      endtask
   endclass

   logic clock;
   logic reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;

   ipv4fwd_req_if req_if ();
   ipv4fwd_rsp_if rsp_if ();

   ipv4_forward_header_update #(.HOLD_WORDS(HOLD)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_if),
      .rsp_bus          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   fwd_scoreboard sb = new();

   logic [7:0] frame_buf [$];  // bytes of the frame being built
   int burst_left;
   int words_sent;
   int cycles       = 0;
   int rx_mode      = 0;
   int rx_mode_left = 0;

   typedef enum int {
      FR_GOOD, FR_BAD_CSUM, FR_ARP, FR_IPV6, FR_OTHER, FR_SHORT, FR_TINY, FR_NOISE
   } frame_kind_type;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Abort on a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: check each output transaction, then pick the next ready value.
   // Stall modes rotate so both long stretches of ready and heavy stalls occur.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.out_word, rsp_if.out_valid_bytes, rsp_if.out_last,
                         rsp_if.verdict);
      if (rx_mode_left == 0) begin
         rx_mode      <= $urandom_range(0, 3);
         rx_mode_left <= $urandom_range(20, 120);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
         0: rsp_if.ready <= !reset;
         1: rsp_if.ready <= !reset && $urandom_range(0, 1);
         2: rsp_if.ready <= !reset && ($urandom_range(0, 7) != 0);
         default: rsp_if.ready <= !reset && ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic logic [7:0] frame_byte(int i);
      return (i < frame_buf.size()) ? frame_buf[i] : 8'h00;
   endfunction

   // Ones' complement checksum over the header as built, checksum field skipped.
   function automatic logic [15:0] built_csum(int ihl);
      int acc;
      int off;
      acc = 0;
      for (int h = 0; h < ihl * 2; h++) begin
         off = ETH_HDR_BYTES + 2 * h;
         if (off == CSUM_OFFSET) continue;
         acc += {frame_byte(off), frame_byte(off + 1)};
         acc = (acc & 16'hffff) + (acc >> 16);
      end
      return ~acc[15:0];
   endfunction

   // Build a frame of the given kind into frame_buf. fill: 0 random,
   // 1 all zeros, 2 all ones.
   task automatic build_frame(frame_kind_type kind, int len, int ihl, int ttl, int fill);
      logic [15:0] c;
      frame_buf.delete();
      for (int i = 0; i < len; i++)
         frame_buf.insert(frame_buf.size(),
                          fill == 1 ? 8'h00 : fill == 2 ? 8'hff : 8'($urandom));
      if (kind == FR_NOISE || kind == FR_TINY) return;
      if (len < ETH_HDR_BYTES) return;
      case (kind)
         FR_ARP:   {frame_buf[12], frame_buf[13]} = ETHTYPE_ARP;
         FR_IPV6:  {frame_buf[12], frame_buf[13]} = ETHTYPE_IPV6;
         FR_OTHER: begin
            {frame_buf[12], frame_buf[13]} = 16'($urandom);
            if ({frame_buf[12], frame_buf[13]} == ETHTYPE_IPV4) frame_buf[13] = 8'h01;
         end
         default: {frame_buf[12], frame_buf[13]} = ETHTYPE_IPV4;
      endcase
      if (kind != FR_GOOD && kind != FR_BAD_CSUM && kind != FR_SHORT) return;
      if (len > ETH_HDR_BYTES) frame_buf[ETH_HDR_BYTES] = {4'h4, 4'(ihl)};
      if (len > 22) frame_buf[22] = 8'(ttl);
      if (len > 25) begin
         c = built_csum(ihl);
         if (kind == FR_BAD_CSUM) c ^= 16'($urandom_range(1, 16'hffff));
         {frame_buf[CSUM_OFFSET], frame_buf[CSUM_OFFSET + 1]} = c;
      end
   endtask

   // Drive one input transaction, honoring the burst/gap pattern.
   task automatic push_word(logic [31:0] w, logic [2:0] vb, logic fin);
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      end
      req_if.valid       <= 1'b1;
      req_if.word        <= w;
      req_if.valid_bytes <= vb;
      req_if.frame_end   <= fin;
      do @(posedge clock); while (!req_if.ready);
      sb.note_input(w, vb, fin);
      burst_left--;
      words_sent++;
   endtask

   // Stream frame_buf; bytes past the end are filled with junk the block masks.
   task automatic send_frame(bit odd_count);
      int          n;
      int          rem;
      logic [31:0] w;
      logic [2:0]  vb;
      n = (frame_buf.size() + 3) / 4;
      for (int k = 0; k < n; k++) begin
         w = $urandom;
         for (int b = 0; b < 4; b++)
            if (4 * k + b < frame_buf.size()) w[8*(3-b) +: 8] = frame_buf[4*k+b];
         if (k + 1 < n) begin
            vb = 3'($urandom_range(0, 7));
         end else begin
            rem = frame_buf.size() - 4 * k;
            vb  = 3'(rem);
            if (rem == 4 && odd_count) begin
               case ($urandom_range(0, 3))
                  0: vb = 3'd0;
                  1: vb = 3'd5;
                  2: vb = 3'd6;
                  default: vb = 3'd7;
               endcase
            end
         end
         push_word(w, vb, k + 1 == n);
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_MIN_TTL) sb.ttl_floor = val;
      else sb.dest_add = val;
   endtask

   // Hold until every owed word has come out, then let the pipeline settle.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic int pick_ttl();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 1;
         2: return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // One random frame; most are well-formed IPv4 so the rewrite path is busy.
   task automatic random_frame();
      int pct;
      int ihl;
      int len;
      pct = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
      len = (ihl > 5 ? 14 + 4 * ihl : 34) + $urandom_range(0, 24);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(34, 14 + 4 * ihl);
      if (pct < 58)      build_frame(FR_GOOD, len, ihl, pick_ttl(), 0);
      else if (pct < 66) build_frame(FR_BAD_CSUM, len, ihl, pick_ttl(), 0);
      else if (pct < 72) build_frame(FR_GOOD, $urandom_range(34, 50),
                                     $urandom_range(0, 4), pick_ttl(), 0);
      else if (pct < 76) build_frame(FR_ARP, $urandom_range(14, 60), 0, 0, 0);
      else if (pct < 79) build_frame(FR_IPV6, $urandom_range(14, 60), 0, 0, 0);
      else if (pct < 83) build_frame(FR_OTHER, $urandom_range(14, 60), 0, 0, 0);
      else if (pct < 88) build_frame(FR_SHORT, $urandom_range(14, 33), 5, pick_ttl(), 0);
      else if (pct < 93) build_frame(FR_TINY, $urandom_range(1, 13), 0, 0, 0);
      else               build_frame(FR_NOISE, $urandom_range(1, 60), 0, 0, 0);
      send_frame($urandom_range(0, 2) == 0);
   endtask

   task automatic random_phase(int target);
      int stop_at;
      stop_at = words_sent + target;
      while (words_sent < stop_at) random_frame();
      drain();
   endtask

   initial begin
      burst_left         = 0;
      words_sent         = 0;
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_MIN_TTL;
      csr_write_data     = '0;
      req_if.valid       = 1'b0;
      req_if.word        = '0;
      req_if.valid_bytes = FULL_WORD_BYTES;
      req_if.frame_end   = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (DRAIN_WAIT) @(posedge clock);

      // Directed frames under the reset csr values.
      build_frame(FR_TINY, 1, 0, 0, 2);             send_frame(0);
      build_frame(FR_TINY, 13, 0, 0, 0);            send_frame(0);
      build_frame(FR_ARP, 20, 0, 0, 0);             send_frame(0);
      build_frame(FR_IPV6, 40, 0, 0, 0);            send_frame(0);
      build_frame(FR_OTHER, 30, 0, 0, 0);           send_frame(0);
      build_frame(FR_SHORT, 20, 5, 64, 0);          send_frame(0);
      build_frame(FR_GOOD, 60, 5, 64, 0);           send_frame(0);
      build_frame(FR_BAD_CSUM, 40, 5, 64, 0);       send_frame(0);
      build_frame(FR_GOOD, 36, 5, 1, 0);            send_frame(1);
      build_frame(FR_GOOD, 40, 3, 9, 0);            send_frame(0);
      build_frame(FR_GOOD, 80, 15, 200, 0);         send_frame(1);
      build_frame(FR_GOOD, 36, 5, 255, 1);          send_frame(1);
      drain();

      // Min TTL zero lets a zero TTL wrap; no destination offset.
      write_csr(CSR_MIN_TTL, 8'd0);
      write_csr(CSR_DEST_ADD, 8'd0);
      build_frame(FR_GOOD, 40, 5, 0, 0);            send_frame(0);
      random_phase(45);

      write_csr(CSR_MIN_TTL, 8'd255);
      write_csr(CSR_DEST_ADD, 8'd255);
      random_phase(35);

      write_csr(CSR_MIN_TTL, 8'($urandom));
      write_csr(CSR_DEST_ADD, 8'($urandom));
      random_phase(55);

      write_csr(CSR_MIN_TTL, 8'd1);
      write_csr(CSR_DEST_ADD, 8'd128);
      random_phase(50);

      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/ipv4fwd_pkg.sv
sv/ipv4fwd_req_if.sv
sv/ipv4fwd_rsp_if.sv
sv/ipv4fwd_ram.sv
sv/ipv4fwd_ctrl.sv
sv/ipv4fwd_dp.sv
sv/ipv4_forward_header_update.sv
dv/testbench.sv
